### src/bitmap_first_free_allocator_assert.svh
// ----------------------------------------------------------------------------
// bitmap first free allocator assertion macros
// concurrent assertion wrappers used by bffa_ctrl
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH

// checked only out of reset
`define BFFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define BFFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// shared constants, types and helpers of the bitmap first free allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int MAP_BITS  = 8192;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = WIDX_W + BIT_W;
    localparam int CNT_W     = 14;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_ALLOC = 2'd2
    } t_req;

    typedef enum logic {
        CFG_ENTRY_COUNT = 1'b0,
        CFG_NUMBER_BASE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]  entry_count;
        logic [DATA_W-1:0] number_base;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic cap_read;
        logic scan;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic hit;
        logic miss;
        logic out_free;
    } t_sts;

    function automatic logic [BIT_W-1:0] lowest_clear(input t_word w);
        logic [BIT_W-1:0] b;
        b = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

### src/bffa_req_if.sv
// ----------------------------------------------------------------------------
// bffa_req_if
// request channel: valid, ready and one request beat
// ----------------------------------------------------------------------------
interface bffa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  word_index;
    logic [31:0] word_value;

    modport source (output valid, output req_type, output word_index, output word_value,
                    input ready);
    modport sink (input valid, input req_type, input word_index, input word_value,
                  output ready);
endinterface

### src/bffa_rsp_if.sv
// ----------------------------------------------------------------------------
// bffa_rsp_if
// result channel: valid, ready and one result beat
// ----------------------------------------------------------------------------
interface bffa_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] alloc_number;
    logic [31:0] read_value;

    modport source (output valid, output found, output alloc_number, output read_value,
                    input ready);
    modport sink (input valid, input found, input alloc_number, input read_value,
                  output ready);
endinterface

### src/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                   i_wr_data,
    input  logic                               i_rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                   o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/bffa_regs.sv
// ----------------------------------------------------------------------------
// bffa_regs
// apb configuration registers: entry count and number base
// ----------------------------------------------------------------------------
module bffa_regs import bffa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0]  i_pwdata,
    output logic [DATA_W-1:0]  o_prdata,
    output logic               o_pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_cfg_idx addr_idx;
    logic     wr_en;

    assign addr_idx = t_cfg_idx'(i_paddr[2]);
    assign wr_en    = i_psel && i_penable && i_pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (addr_idx)
                CFG_ENTRY_COUNT: n_cfg.entry_count = i_pwdata[CNT_W-1:0];
                CFG_NUMBER_BASE: n_cfg.number_base = i_pwdata;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_count <= '0;
            r_cfg.number_base <= DATA_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (addr_idx)
            CFG_ENTRY_COUNT: o_prdata = DATA_W'(r_cfg.entry_count);
            CFG_NUMBER_BASE: o_prdata = r_cfg.number_base;
            default:         o_prdata = '0;
        endcase
    end

    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

endmodule

### src/bffa_dp.sv
// ----------------------------------------------------------------------------
// bffa_dp
// datapath: map ram, word scan, result and output registers
// ----------------------------------------------------------------------------
module bffa_dp import bffa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  t_cfg        i_cfg,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_word_index,
    input  logic [31:0] i_word_value,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic        o_found,
    output logic [31:0] o_alloc_number,
    output logic [31:0] o_read_value
);

    logic              ram_wr_en;
    logic [WIDX_W-1:0] ram_wr_addr;
    t_word             ram_wr_data;
    logic              ram_rd_en;
    logic [WIDX_W-1:0] ram_rd_addr;
    t_word             ram_rd_data;

    logic [CNT_W-1:0]  count_sat;
    logic [CNT_W-1:0]  count_m1;
    logic [WIDX_W-1:0] last_word;
    logic [BIT_W-1:0]  cnt_lo;
    logic              idx_ok;
    logic              is_load;
    logic              is_read;
    logic              is_alloc;

    logic [WIDX_W-1:0] r_issue;
    logic              r_issue_done;
    logic              r_chk_vld;
    logic [WIDX_W-1:0] r_chk_word;
    logic              r_rd_ok;

    logic              r_found;
    logic [IDX_W-1:0]  r_idx;
    logic [31:0]       r_rval;

    logic              r_out_vld;
    logic              r_o_found;
    logic [31:0]       r_o_num;
    logic [31:0]       r_o_rval;

    t_word             lim_mask;
    t_word             chk_data;
    logic [BIT_W-1:0]  hit_bit;
    logic              hit;
    logic              miss;

    // effective entry count and last word to scan
    assign count_sat = (i_cfg.entry_count > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS)
                                                             : i_cfg.entry_count;
    assign count_m1  = count_sat - CNT_W'(1);
    assign last_word = WIDX_W'(count_m1 >> BIT_W);
    assign cnt_lo    = count_sat[BIT_W-1:0];
    assign idx_ok    = 32'(i_word_index) < 32'(NUM_WORDS);

    assign is_load  = i_req_type == REQ_LOAD;
    assign is_read  = i_req_type == REQ_READ;
    assign is_alloc = i_req_type == REQ_ALLOC;

    // entries past the count in the last word read as used
    assign lim_mask = ((r_chk_word == last_word) && (cnt_lo != '0))
                    ? ~((t_word'(1) << cnt_lo) - t_word'(1)) : '0;
    assign chk_data = ram_rd_data | lim_mask;
    assign hit_bit  = lowest_clear(chk_data);
    assign hit      = r_chk_vld && (chk_data != '1);
    assign miss     = r_chk_vld && (chk_data == '1) && (r_chk_word == last_word);

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = WIDX_W'(i_word_index);
        ram_wr_data = t_word'(i_word_value);
        if (i_cmd.accept && is_load && idx_ok) begin
            ram_wr_en = 1'b1;
        end else if (i_cmd.scan && hit) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_chk_word;
            ram_wr_data = ram_rd_data | (t_word'(1) << hit_bit);
        end
    end

    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = WIDX_W'(i_word_index);
        if (i_cmd.accept && is_read) begin
            ram_rd_en = idx_ok;
        end else if (i_cmd.scan && !r_issue_done) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = r_issue;
        end
    end

    bffa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // scan pointers and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_done <= 1'b1;
            r_chk_vld    <= 1'b0;
        end else if (i_cmd.accept) begin
            r_issue_done <= !is_alloc;
            r_chk_vld    <= 1'b0;
        end else if (i_cmd.scan) begin
            r_chk_vld <= !r_issue_done;
            if (!r_issue_done && (r_issue == last_word)) begin
                r_issue_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_issue <= '0;
            r_rd_ok <= idx_ok;
            r_found <= 1'b0;
            r_idx   <= '0;
            r_rval  <= '0;
        end else begin
            if (i_cmd.scan) begin
                r_chk_word <= r_issue;
                if (!r_issue_done) begin
                    r_issue <= r_issue + WIDX_W'(1);
                end
                if (hit) begin
                    r_found <= 1'b1;
                    r_idx   <= {r_chk_word, hit_bit};
                end
            end
            if (i_cmd.cap_read) begin
                r_rval <= r_rd_ok ? ram_rd_data[31:0] : 32'd0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_found <= r_found;
            r_o_num   <= r_found ? (i_cfg.number_base + 32'(r_idx)) : 32'd0;
            r_o_rval  <= r_rval;
        end
    end

    assign o_sts.count_zero = count_sat == '0;
    assign o_sts.hit        = hit;
    assign o_sts.miss       = miss;
    assign o_sts.out_free   = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid    = r_out_vld;
    assign o_found        = r_o_found;
    assign o_alloc_number = r_o_num;
    assign o_read_value   = r_o_rval;

endmodule

### src/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// controller: request sequencing for load, read and allocate
// ----------------------------------------------------------------------------
`include "bitmap_first_free_allocator_assert.svh"

module bffa_ctrl import bffa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [1:0] i_req_type,
    output logic       o_req_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_type)
                        REQ_READ:  n_state = S_READ;
                        REQ_ALLOC: n_state = i_sts.count_zero ? S_DONE : S_SCAN;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.cap_read = 1'b1;
                n_state        = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.miss) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `BFFA_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> r_state == S_IDLE, "not idle after reset")
    `BFFA_ASSERT(a_read_next, i_clk, i_rst_n, (r_state == S_IDLE) && i_req_valid && (i_req_type == REQ_READ) |=> r_state == S_READ, "read beat did not go to read capture")
    `BFFA_ASSERT(a_hit_done, i_clk, i_rst_n, (r_state == S_SCAN) && i_sts.hit |=> r_state == S_DONE, "scan continued after hit")
    `BFFA_ASSERT(a_done_hold, i_clk, i_rst_n, (r_state == S_DONE) && !i_sts.out_free |=> r_state == S_DONE, "result dropped while output busy")

endmodule

### src/bitmap_first_free_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// free map of entries in 32-bit words with first free allocate
// ----------------------------------------------------------------------------
//  channel   dir   handshake             beat
//  i_req     in    valid / ready         req_type, word_index, word_value
//  o_rsp     out   valid / ready         found, alloc_number, read_value
//  apb       in    psel, penable, pwrite entry_count @ 0x0, number_base @ 0x4
//
//  allocate scans from word 0 up to the map word holding the first free
//  entry or the last word; the scan reads one map word a cycle through the
//  ram read port
//  one request at a time; a new request is taken while a result waits
//  in the output register
//  reset is synchronous; the map ram holds no reset value until loaded
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator import bffa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bffa_req_if.sink           i_req,
    bffa_rsp_if.source         o_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0]  i_pwdata,
    output logic [DATA_W-1:0]  o_prdata,
    output logic               o_pready
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    bffa_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    bffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bffa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg          (cfg),
        .i_req_type     (i_req.req_type),
        .i_word_index   (i_req.word_index),
        .i_word_value   (i_req.word_value),
        .o_rsp_valid    (o_rsp.valid),
        .i_rsp_ready    (o_rsp.ready),
        .o_found        (o_rsp.found),
        .o_alloc_number (o_rsp.alloc_number),
        .o_read_value   (o_rsp.read_value)
    );

    assign i_req.ready = req_ready;

endmodule

### sim/bitmap_first_free_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_tb
// self-checking bench for the bitmap first free allocator: a directed table
// of loads, reads, allocates and register writes, then random phases under
// several settings with idle and stall patterns on both channels; each result
// is checked against its typed table row or a bench-side copy of the free map
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_tb;
    import bffa_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 64;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 800000;
    localparam int DIRECTED_ROWS  = 30;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  word_index;
        logic [31:0] word_value;
    } t_request;

    typedef struct packed {
        logic        found;
        logic [31:0] alloc_number;
        logic [31:0] read_value;
    } t_result;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    reg_sel;
        logic [1:0]  req_type;
        logic [7:0]  word_index;
        logic [31:0] word_value;
        logic        typed;
        t_result     exp;
    } t_row;

    localparam t_result NONE = '{1'b0, 32'h0, 32'h0};

    localparam t_row DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_UNKNOWN, 8'd255, 32'hFFFF_FFFF, 1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_LOAD,    8'd0,   32'h0,         1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_READ,    8'd0,   32'h0,         1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_LOAD,    8'd0,   32'hFFFF_FFFF, 1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_READ,    8'd0,   32'h0,         1'b1,
          '{1'b0, 32'h0, 32'hFFFF_FFFF}},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1, NONE},
        '{ROW_CFG, CFG_ENTRY_COUNT, REQ_LOAD,    8'd0,   32'd1,         1'b0, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_LOAD,    8'd0,   32'hFFFF_FFFE, 1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1,
          '{1'b1, 32'd1, 32'h0}},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_READ,    8'd0,   32'h0,         1'b1,
          '{1'b0, 32'h0, 32'hFFFF_FFFF}},
        '{ROW_CFG, CFG_NUMBER_BASE, REQ_LOAD,    8'd0,   32'hFFFF_FFFF, 1'b0, NONE},
        '{ROW_CFG, CFG_ENTRY_COUNT, REQ_LOAD,    8'd0,   32'd64,        1'b0, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_LOAD,    8'd1,   32'h7FFF_FFFF, 1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1,
          '{1'b1, 32'd62, 32'h0}},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1, NONE},
        '{ROW_CFG, CFG_ENTRY_COUNT, REQ_LOAD,    8'd0,   32'd16383,     1'b0, NONE},
        '{ROW_CFG, CFG_NUMBER_BASE, REQ_LOAD,    8'd0,   32'h0,         1'b0, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_LOAD,    8'd2,   32'h0,         1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1,
          '{1'b1, 32'd64, 32'h0}},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_LOAD,    8'd255, 32'hA5A5_5A5A, 1'b1, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_READ,    8'd255, 32'h0,         1'b1,
          '{1'b0, 32'h0, 32'hA5A5_5A5A}},
        '{ROW_CFG, CFG_ENTRY_COUNT, REQ_LOAD,    8'd0,   32'd65,        1'b0, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1, NONE},
        '{ROW_CFG, CFG_ENTRY_COUNT, REQ_LOAD,    8'd0,   32'd8192,      1'b0, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b1,
          '{1'b1, 32'd65, 32'h0}},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_ALLOC,   8'd0,   32'h0,         1'b0, NONE},
        '{ROW_REQ, CFG_ENTRY_COUNT, REQ_UNKNOWN, 8'd0,   32'h0,         1'b1, NONE}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    bffa_req_if req_bus ();
    bffa_rsp_if rsp_bus ();

    bitmap_first_free_allocator dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_bus),
        .o_rsp     (rsp_bus),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    always #2 clk = ~clk;

    // bench copy of the free map and the registers
    t_word            map_copy [NUM_WORDS];
    bit               loaded [NUM_WORDS];
    logic [CNT_W-1:0] cur_count;
    logic [31:0]      cur_base;

    t_result pending_results [$];
    int      errors        = 0;
    int      n_requests    = 0;
    int      n_allocs      = 0;
    int      n_found       = 0;
    int      n_settings    = 0;
    int      n_checked     = 0;
    int      cycle_count   = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      long_hold     = 1'b0;
    int      held_cycles   = 0;

    function automatic int scan_count();
        return (int'(cur_count) > MAP_BITS) ? MAP_BITS : int'(cur_count);
    endfunction

    // first never-loaded word an allocate would scan, -1 if none
    function automatic int first_unloaded_word();
        int lim;
        lim = scan_count();
        for (int w = 0; w < NUM_WORDS; w++) begin
            if (w * WORD_BITS >= lim) return -1;
            if (!loaded[w]) return w;
            for (int b = 0; b < WORD_BITS && w * WORD_BITS + b < lim; b++) begin
                if (!map_copy[w][b]) return -1;
            end
        end
        return -1;
    endfunction

    function automatic t_result apply_request(input t_request r);
        t_result res;
        int      lim;
        res = NONE;
        lim = scan_count();
        n_requests++;
        case (r.req_type)
            REQ_LOAD: begin
                map_copy[r.word_index] = r.word_value;
                loaded[r.word_index]   = 1'b1;
            end
            REQ_READ: res.read_value = map_copy[r.word_index];
            REQ_ALLOC: begin
                n_allocs++;
                for (int w = 0; w < NUM_WORDS; w++) begin
                    if (w * WORD_BITS >= lim) return res;
                    for (int b = 0; b < WORD_BITS && w * WORD_BITS + b < lim; b++) begin
                        if (!map_copy[w][b]) begin
                            map_copy[w][b]   = 1'b1;
                            res.found        = 1'b1;
                            res.alloc_number = 32'(w * WORD_BITS + b) + cur_base;
                            n_found++;
                            return res;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] map_pattern();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'hFFFF_FFFF;
            4, 5:       return ~(32'h1 << $urandom_range(0, 31));
            6, 7:       return $urandom();
            8:          return 32'h0;
            default:    return $urandom() | $urandom();
        endcase
    endfunction

    // half the picks are allocates over a loaded map; allocates that would scan an
    // unloaded word turn into a load of that word
    function automatic t_request make_request();
        t_request r;
        int       pick;
        int       blocker;
        pick         = $urandom_range(0, 99);
        r.req_type   = REQ_LOAD;
        r.word_index = 8'($urandom_range(0, NUM_WORDS - 1));
        r.word_value = map_pattern();
        if (pick < 5) begin
            r.req_type   = REQ_UNKNOWN;
            r.word_value = $urandom();
        end else if (pick >= 30 && pick < 50 && loaded[r.word_index]) begin
            r.req_type = REQ_READ;
        end else if (pick >= 50) begin
            blocker = first_unloaded_word();
            if (blocker < 0) begin
                r.req_type = REQ_ALLOC;
            end else begin
                r.word_index = 8'(blocker);
            end
        end
        return r;
    endfunction

    task automatic apb_transfer(input logic wr, input logic [PADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input t_cfg_idx sel, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;
        apb_transfer(1'b0, PADDR_W'(4 * int'(sel)), '0, got);
        if (got !== want) begin
            $display("%0t register %s readback: expected %0h got %0h",
                     $time, sel.name(), want, got);
            errors++;
        end
    endtask

    task automatic write_reg(input t_cfg_idx sel, input logic [31:0] value);
        logic [DATA_W-1:0] unused;
        apb_transfer(1'b1, PADDR_W'(4 * int'(sel)), value, unused);
        n_settings++;
        if (sel == CFG_ENTRY_COUNT) begin
            cur_count = value[CNT_W-1:0];
            check_reg(sel, DATA_W'(cur_count));
        end else begin
            cur_base = value;
            check_reg(sel, value);
        end
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic offer_request(input t_request r, input logic typed, input t_result want);
        t_result res;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= r.req_type;
        req_bus.word_index <= r.word_index;
        req_bus.word_value <= r.word_value;
        do @(posedge clk); while (!req_bus.ready);
        res = apply_request(r);
        pending_results.push_back(typed ? want : res);
    endtask

    // result side stalls
    always @(posedge clk) begin
        if (long_hold && held_cycles < HOLD_CYCLES) begin
            held_cycles   <= held_cycles + 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t result beat with none expected: found %0b number %0h read %0h",
                         $time, rsp_bus.found, rsp_bus.alloc_number, rsp_bus.read_value);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (rsp_bus.found !== want.found) begin
                    $display("%0t found: expected %0b got %0b",
                             $time, want.found, rsp_bus.found);
                    errors++;
                end
                if (rsp_bus.alloc_number !== want.alloc_number) begin
                    $display("%0t alloc_number: expected %0h got %0h",
                             $time, want.alloc_number, rsp_bus.alloc_number);
                    errors++;
                end
                if (rsp_bus.read_value !== want.read_value) begin
                    $display("%0t read_value: expected %0h got %0h",
                             $time, want.read_value, rsp_bus.read_value);
                    errors++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    initial begin
        t_request         rq;
        logic [CNT_W-1:0] cnt;
        logic [31:0]      base;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = REQ_LOAD;
        req_bus.word_index = '0;
        req_bus.word_value = '0;
        rsp_bus.ready      = 1'b0;
        cur_count          = '0;
        cur_base           = 32'd1;
        for (int w = 0; w < NUM_WORDS; w++) begin
            map_copy[w] = '0;
            loaded[w]   = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_reg(CFG_ENTRY_COUNT, '0);
        check_reg(CFG_NUMBER_BASE, 32'd1);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED_PLAN[i].kind == ROW_CFG) begin
                drain();
                write_reg(DIRECTED_PLAN[i].reg_sel, DIRECTED_PLAN[i].word_value);
            end else begin
                rq = '{DIRECTED_PLAN[i].req_type, DIRECTED_PLAN[i].word_index,
                       DIRECTED_PLAN[i].word_value};
                offer_request(rq, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].exp);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    cnt = 14'd8192;  base = 32'd1;
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    cnt = 14'd16383; base = 32'hFFFF_FFFF;
                    send_idle_pct = 68; recv_stall_pct = 0;
                end
                2: begin
                    cnt = CNT_W'($urandom_range(1, 8191)); base = $urandom();
                    send_idle_pct = 0;  recv_stall_pct = 68;
                end
                3: begin
                    cnt = 14'd1;     base = 32'h0;
                    send_idle_pct = 17; recv_stall_pct = 17;
                end
                4: begin
                    cnt = 14'd8192;  base = $urandom();
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                5: begin
                    cnt = CNT_W'($urandom_range(0, 16383)); base = 32'hFFFF_FFF0;
                    send_idle_pct = 17; recv_stall_pct = 17;
                end
                default: begin
                    cnt = 14'd33;    base = 32'h8000_0000;
                    send_idle_pct = 68; recv_stall_pct = 68;
                end
            endcase
            write_reg(CFG_ENTRY_COUNT, 32'(cnt));
            write_reg(CFG_NUMBER_BASE, base);
            // long result-side hold while requests keep coming
            if (p == 4) long_hold <= 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                offer_request(make_request(), 1'b0, NONE);
            end
        end
        drain();

        $display("ran %0d requests (%0d allocates, %0d found) over %0d register writes",
                 n_requests, n_allocs, n_found, n_settings);
        $display("checked %0d result beats with %0d mismatches", n_checked, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/bffa_pkg.sv
src/bffa_req_if.sv
src/bffa_rsp_if.sv
src/bffa_ram.sv
src/bffa_regs.sv
src/bffa_dp.sv
src/bffa_ctrl.sv
src/bitmap_first_free_allocator.sv
sim/bitmap_first_free_allocator_tb.sv
